FILE: hw/rtl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types, field widths and codes of the best-fit partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfpa_pkg;

  localparam int MODE_W  = 2;
  localparam int SIZE_W  = 16;
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 4;
  localparam int TOTAL_W = 24;
  localparam int FREE_W  = 20;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [FREE_W-1:0]  free_t;

  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_LOAD   = 2'd1;
  localparam mode_t MODE_ALLOC  = 2'd2;
  localparam mode_t MODE_REPORT = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_NOFIT = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  localparam total_t SUM_MAX  = 24'hFFFFFF;
  localparam free_t  FREE_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    SCAN_BEST,
    SCAN_FREE,
    SCAN_EXT
  } scan_op_e;

  typedef struct packed {
    logic     init;
    logic     step;
    scan_op_e op;
  } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bfpa_if.sv
// ----------------------------------------------------------------------------
// bfpa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfpa_req_if;
  import bfpa_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  size_t size_value;

  modport source (output valid, output mode, output size_value, input ready);
  modport sink   (input valid, input mode, input size_value, output ready);
endinterface

interface bfpa_rsp_if;
  import bfpa_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    granted;
  index_t  partition_index;
  size_t   internal_frag;
  total_t  internal_total;
  free_t   free_total;
  size_t   external_frag;

  modport source (
    output valid, output status, output granted, output partition_index,
    output internal_frag, output internal_total, output free_total,
    output external_frag, input ready
  );
  modport sink (
    input valid, input status, input granted, input partition_index,
    input internal_frag, input internal_total, input free_total,
    input external_frag, output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Best-fit fixed-partition allocator with fragmentation reporting.
// ----------------------------------------------------------------------------
// Clear and load requests are answered straight from the idle state. An
// allocation walks the loaded partitions one per cycle through a single
// compare unit fed by the registered read port of the partition memory; a
// report walks the partitions and then the failure log. One request is in
// flight at a time; the response waits in an output register and the next
// request is taken once it has been delivered. The size memories need no
// clearing after reset: the fill counts bound every read.
`default_nettype none

module best_fit_partition_allocator #(
  parameter int PARTITIONS       = 16,
  parameter int FAILED_LOG_DEPTH = 16,
  parameter int SIZE_BITS        = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bfpa_req_if.sink            req_i,
  bfpa_rsp_if.source          rsp_o
);
  import bfpa_pkg::*;

  localparam int SW   = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam int PIW  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int FIW  = (FAILED_LOG_DEPTH > 1) ? $clog2(FAILED_LOG_DEPTH) : 1;
  localparam int PCW  = $clog2(PARTITIONS + 1);
  localparam int FCW  = $clog2(FAILED_LOG_DEPTH + 1);
  localparam int CNTW = (PCW > FCW) ? PCW : FCW;
  localparam int FSW  = SW + PCW;
  localparam int FXW  = (FSW > FREE_W) ? FSW : FREE_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PSCAN = 2'd1;
  localparam logic [1:0] ST_FSCAN = 2'd2;

  logic [1:0]      state_q, state_d;
  mode_t           mode_q, mode_d;
  logic [SW-1:0]   req_size_q, req_size_d;
  logic [PCW-1:0]  p_count_q, p_count_d;
  logic [FCW-1:0]  f_count_q, f_count_d;
  total_t          frag_sum_q, frag_sum_d;
  logic [PARTITIONS-1:0] used_q, used_d;
  logic [CNTW-1:0] issue_q, issue_d;
  logic            rd_v_q, rd_v_d;
  logic [CNTW-1:0] rd_idx_q, rd_idx_d;

  logic            rsp_valid_q, rsp_valid_d;
  status_t         rsp_status_q, rsp_status_d;
  logic            rsp_granted_q, rsp_granted_d;
  index_t          rsp_index_q, rsp_index_d;
  size_t           rsp_frag_q, rsp_frag_d;
  total_t          rsp_total_q, rsp_total_d;
  free_t           rsp_free_q, rsp_free_d;
  size_t           rsp_ext_q, rsp_ext_d;

  logic            req_acc;
  logic [SW-1:0]   size_in;
  logic [CNTW-1:0] limit;

  logic            pm_we;
  logic [SW-1:0]   pm_rdata;
  logic            fm_we;
  logic [SW-1:0]   fm_rdata;

  scan_ctrl_t      scan_ctrl;
  logic            sc_found;
  logic [PIW-1:0]  sc_best_idx;
  logic [SW-1:0]   sc_best_size;
  logic [FSW-1:0]  sc_free_sum;
  logic [SW-1:0]   sc_ext;

  logic [SW-1:0]   frag;
  logic [TOTAL_W:0] frag_acc;
  logic [FXW-1:0]  free_x;

  assign req_acc = req_i.valid && req_i.ready;
  assign size_in = req_i.size_value[SW-1:0];
  assign limit   = (state_q == ST_FSCAN) ? CNTW'(f_count_q) : CNTW'(p_count_q);

  assign frag     = sc_best_size - req_size_q;
  assign frag_acc = {1'b0, frag_sum_q} + (TOTAL_W + 1)'(frag);
  assign free_x   = FXW'(sc_free_sum);

  bfpa_mem #(
    .DEPTH (PARTITIONS),
    .WIDTH (SW)
  ) u_part_mem (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (p_count_q[PIW-1:0]),
    .wdata_i (size_in),
    .raddr_i (issue_q[PIW-1:0]),
    .rdata_o (pm_rdata)
  );

  bfpa_mem #(
    .DEPTH (FAILED_LOG_DEPTH),
    .WIDTH (SW)
  ) u_fail_mem (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (f_count_q[FIW-1:0]),
    .wdata_i (req_size_q),
    .raddr_i (issue_q[FIW-1:0]),
    .rdata_o (fm_rdata)
  );

  bfpa_scan #(
    .IDXW (PIW),
    .SW   (SW),
    .FSW  (FSW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .elem_i      ((state_q == ST_FSCAN) ? fm_rdata : pm_rdata),
    .used_i      (used_q[rd_idx_q[PIW-1:0]]),
    .idx_i       (rd_idx_q[PIW-1:0]),
    .req_size_i  (req_size_q),
    .found_o     (sc_found),
    .best_idx_o  (sc_best_idx),
    .best_size_o (sc_best_size),
    .free_sum_o  (sc_free_sum),
    .ext_o       (sc_ext)
  );

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    req_size_d    = req_size_q;
    p_count_d     = p_count_q;
    f_count_d     = f_count_q;
    frag_sum_d    = frag_sum_q;
    used_d        = used_q;
    issue_d       = issue_q;
    rd_v_d        = 1'b0;
    rd_idx_d      = issue_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_status_d  = rsp_status_q;
    rsp_granted_d = rsp_granted_q;
    rsp_index_d   = rsp_index_q;
    rsp_frag_d    = rsp_frag_q;
    rsp_total_d   = rsp_total_q;
    rsp_free_d    = rsp_free_q;
    rsp_ext_d     = rsp_ext_q;
    pm_we         = 1'b0;
    fm_we         = 1'b0;
    scan_ctrl.init = 1'b0;
    scan_ctrl.step = rd_v_q;
    if (state_q == ST_FSCAN) begin
      scan_ctrl.op = SCAN_EXT;
    end else if (mode_q == MODE_ALLOC) begin
      scan_ctrl.op = SCAN_BEST;
    end else begin
      scan_ctrl.op = SCAN_FREE;
    end

    unique case (state_q) inside
      ST_IDLE: begin
        if (req_acc) begin
          rsp_status_d  = STATUS_OK;
          rsp_granted_d = 1'b0;
          rsp_index_d   = '0;
          rsp_frag_d    = '0;
          rsp_free_d    = '0;
          rsp_ext_d     = '0;
          rsp_total_d   = frag_sum_q;
          unique case (req_i.mode) inside
            MODE_CLEAR: begin
              used_d      = '0;
              p_count_d   = '0;
              f_count_d   = '0;
              frag_sum_d  = '0;
              rsp_total_d = '0;
              rsp_valid_d = 1'b1;
            end
            MODE_LOAD: begin
              if (p_count_q != PCW'(PARTITIONS)) begin
                pm_we                      = 1'b1;
                used_d[p_count_q[PIW-1:0]] = 1'b0;
                p_count_d                  = p_count_q + 1'b1;
              end else begin
                rsp_status_d = STATUS_FULL;
              end
              rsp_valid_d = 1'b1;
            end
            MODE_ALLOC, MODE_REPORT: begin
              mode_d         = req_i.mode;
              req_size_d     = size_in;
              issue_d        = '0;
              scan_ctrl.init = 1'b1;
              state_d        = ST_PSCAN;
            end
            default: ;
          endcase
        end
      end
      ST_PSCAN, ST_FSCAN: begin
        if (issue_q != limit) begin
          issue_d = issue_q + 1'b1;
          rd_v_d  = 1'b1;
        end else if (!rd_v_q) begin
          // last entry has gone through the compare unit
          if (state_q == ST_FSCAN) begin
            rsp_free_d  = (free_x > FXW'(FREE_MAX)) ? FREE_MAX : free_x[FREE_W-1:0];
            rsp_ext_d   = SIZE_W'(sc_ext);
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else if (mode_q == MODE_ALLOC) begin
            if (sc_found) begin
              used_d[sc_best_idx] = 1'b1;
              frag_sum_d    = frag_acc[TOTAL_W] ? SUM_MAX : frag_acc[TOTAL_W-1:0];
              rsp_total_d   = frag_acc[TOTAL_W] ? SUM_MAX : frag_acc[TOTAL_W-1:0];
              rsp_granted_d = 1'b1;
              rsp_index_d   = INDEX_W'(sc_best_idx);
              rsp_frag_d    = SIZE_W'(frag);
            end else if (f_count_q != FCW'(FAILED_LOG_DEPTH)) begin
              fm_we        = 1'b1;
              f_count_d    = f_count_q + 1'b1;
              rsp_status_d = STATUS_NOFIT;
            end else begin
              rsp_status_d = STATUS_FULL;
            end
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            issue_d = '0;
            state_d = ST_FSCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_count_q   <= '0;
      f_count_q   <= '0;
      frag_sum_q  <= '0;
      used_q      <= '0;
      issue_q     <= '0;
      rd_v_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_count_q   <= p_count_d;
      f_count_q   <= f_count_d;
      frag_sum_q  <= frag_sum_d;
      used_q      <= used_d;
      issue_q     <= issue_d;
      rd_v_q      <= rd_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    req_size_q    <= req_size_d;
    rd_idx_q      <= rd_idx_d;
    rsp_status_q  <= rsp_status_d;
    rsp_granted_q <= rsp_granted_d;
    rsp_index_q   <= rsp_index_d;
    rsp_frag_q    <= rsp_frag_d;
    rsp_total_q   <= rsp_total_d;
    rsp_free_q    <= rsp_free_d;
    rsp_ext_q     <= rsp_ext_d;
  end

  assign req_i.ready           = (state_q == ST_IDLE) && !rsp_valid_q;
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.granted         = rsp_granted_q;
  assign rsp_o.partition_index = rsp_index_q;
  assign rsp_o.internal_frag   = rsp_frag_q;
  assign rsp_o.internal_total  = rsp_total_q;
  assign rsp_o.free_total      = rsp_free_q;
  assign rsp_o.external_frag   = rsp_ext_q;

  a_p_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_count_q <= PCW'(PARTITIONS))
    else $error("partition count beyond table depth");

  a_f_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_count_q <= FCW'(FAILED_LOG_DEPTH))
    else $error("failure count beyond log depth");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_granted_q |-> rsp_status_q == STATUS_OK)
    else $error("grant reported with error status");

  a_no_rsp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !rsp_valid_q)
    else $error("response pending while a scan runs");

  a_scan_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> state_q == ST_IDLE && !rd_v_q)
    else $error("response raised with scan still active");

endmodule

`default_nettype wire

FILE: hw/rtl/bfpa_mem.sv
// ----------------------------------------------------------------------------
// bfpa_mem
// Single write port, single registered read port storage array.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpa_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bfpa_scan.sv
// ----------------------------------------------------------------------------
// bfpa_scan
// Shared compare/accumulate unit, fed one table entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpa_scan #(
  parameter int IDXW = 4,
  parameter int SW   = 16,
  parameter int FSW  = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfpa_pkg::scan_ctrl_t ctrl_i,
  input  logic [SW-1:0]       elem_i,
  input  logic                used_i,
  input  logic [IDXW-1:0]     idx_i,
  input  logic [SW-1:0]       req_size_i,
  output logic                found_o,
  output logic [IDXW-1:0]     best_idx_o,
  output logic [SW-1:0]       best_size_o,
  output logic [FSW-1:0]      free_sum_o,
  output logic [SW-1:0]       ext_o
);
  import bfpa_pkg::*;

  logic            found_q;
  logic [IDXW-1:0] best_idx_q;
  logic [SW-1:0]   best_size_q;
  logic [FSW-1:0]  free_sum_q;
  logic [SW-1:0]   ext_q;

  logic fits, smaller, below, larger;

  assign fits    = elem_i >= req_size_i;
  assign smaller = elem_i < best_size_q;
  assign below   = FSW'(elem_i) < free_sum_q;
  assign larger  = elem_i > ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_size_q <= '0;
      free_sum_q  <= '0;
      ext_q       <= '0;
    end else if (ctrl_i.init) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_size_q <= '0;
      free_sum_q  <= '0;
      ext_q       <= '0;
    end else if (ctrl_i.step) begin
      case (ctrl_i.op)
        SCAN_BEST: begin
          // lowest index wins on ties: replace only on strictly smaller
          if (!used_i && fits && (!found_q || smaller)) begin
            found_q     <= 1'b1;
            best_idx_q  <= idx_i;
            best_size_q <= elem_i;
          end
        end
        SCAN_FREE: begin
          if (!used_i) begin
            free_sum_q <= free_sum_q + FSW'(elem_i);
          end
        end
        SCAN_EXT: begin
          if (below && larger) begin
            ext_q <= elem_i;
          end
        end
        default: ;
      endcase
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_size_o = best_size_q;
  assign free_sum_o  = free_sum_q;
  assign ext_o       = ext_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Best-fit partition allocator testbench
// Drives clear, load, allocate and report requests over the valid/ready
// request channel and checks every response against a best-fit predictor
// or a typed row's fixed response. A short list of directed requests comes
// first, then random episodes that usually clear the tables, load partitions and
// mix allocations and reports. Each of four phases runs under different
// sender and receiver idling; the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------

module testbench;
  import bfpa_pkg::*;

  localparam int PARTS       = 16;
  localparam int LOG_DEPTH   = 16;
  localparam int RAND_ITEMS  = 950;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t status;
    logic    granted;
    index_t  index;
    size_t   ifrag;
    total_t  itotal;
    free_t   ftotal;
    size_t   efrag;
  } alloc_rsp_t;

  typedef struct {
    mode_t      mode;
    size_t      req_size;
    int         reps;
    logic       typed;
    alloc_rsp_t want;
  } dir_row_t;

  localparam alloc_rsp_t RSP_ZERO  = '0;
  localparam alloc_rsp_t RSP_NOFIT =
    alloc_rsp_t'{STATUS_NOFIT, 1'b0, 4'd0, 16'd0, 24'd0, 20'd0, 16'd0};
  localparam alloc_rsp_t RSP_FULL  =
    alloc_rsp_t'{STATUS_FULL, 1'b0, 4'd0, 16'd0, 24'd0, 20'd0, 16'd0};

  localparam int DIR_ROWS = 18;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_REPORT, 16'h0000, 1,  1'b1, RSP_ZERO},
    '{MODE_ALLOC,  16'hFFFF, 1,  1'b1, RSP_NOFIT},   // empty table
    '{MODE_CLEAR,  16'hFFFF, 1,  1'b1, RSP_ZERO},
    '{MODE_LOAD,   16'h0000, 1,  1'b1, RSP_ZERO},
    '{MODE_LOAD,   16'd100,  2,  1'b1, RSP_ZERO},
    '{MODE_LOAD,   16'hFFFF, 13, 1'b1, RSP_ZERO},
    '{MODE_LOAD,   16'h5A5A, 1,  1'b1, RSP_FULL},    // table full
    '{MODE_ALLOC,  16'h0000, 2,  1'b0, RSP_ZERO},    // zero requests get size 0, then size 100
    '{MODE_ALLOC,  16'd50,   1,  1'b0, RSP_ZERO},    // takes the other partition of size 100
    '{MODE_ALLOC,  16'hFFFF, 1,  1'b0, RSP_ZERO},
    '{MODE_REPORT, 16'hA5A5, 1,  1'b0, RSP_ZERO},
    '{MODE_CLEAR,  16'h0000, 1,  1'b1, RSP_ZERO},
    '{MODE_LOAD,   16'd10,   2,  1'b1, RSP_ZERO},
    '{MODE_ALLOC,  16'd15,   1,  1'b0, RSP_ZERO},
    '{MODE_ALLOC,  16'd20,   1,  1'b0, RSP_ZERO},
    '{MODE_REPORT, 16'h0000, 1,  1'b0, RSP_ZERO},    // failed size equal to free sum is skipped
    '{MODE_ALLOC,  16'd10,   1,  1'b0, RSP_ZERO},
    '{MODE_REPORT, 16'h0000, 1,  1'b0, RSP_ZERO}
  };

  logic clk_i;
  logic rst_ni;

  bfpa_req_if req_if ();
  bfpa_rsp_if rsp_if ();

  best_fit_partition_allocator #(
    .PARTITIONS       (PARTS),
    .FAILED_LOG_DEPTH (LOG_DEPTH),
    .SIZE_BITS        (SIZE_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predictor state
  size_t  part_size  [PARTS];
  logic   part_taken [PARTS];
  int     part_cnt;
  size_t  fail_log   [LOG_DEPTH];
  int     fail_cnt;
  total_t frag_acc;

  alloc_rsp_t expected_rsps [$];
  int errors        = 0;
  int accepted_reqs = 0;
  int rsp_seen      = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asked    = 0;
  int hold_given    = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic alloc_rsp_t best_fit_step(input mode_t m, input size_t s);
    alloc_rsp_t r;
    logic       found;
    int         best;
    longint     free_sum;
    logic [TOTAL_W:0] t;
    r = '0;
    found = 1'b0;
    best = 0;
    free_sum = 0;
    case (m)
      MODE_CLEAR: begin
        for (int j = 0; j < PARTS; j++) part_taken[j] = 1'b0;
        part_cnt = 0;
        fail_cnt = 0;
        frag_acc = '0;
      end
      MODE_LOAD: begin
        if (part_cnt < PARTS) begin
          part_size[part_cnt]  = s;
          part_taken[part_cnt] = 1'b0;
          part_cnt++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      MODE_ALLOC: begin
        for (int j = 0; j < part_cnt; j++) begin
          if (!part_taken[j] && part_size[j] >= s &&
              (!found || part_size[j] < part_size[best])) begin
            found = 1'b1;
            best  = j;
          end
        end
        if (found) begin
          part_taken[best] = 1'b1;
          r.granted = 1'b1;
          r.index   = index_t'(best);
          r.ifrag   = part_size[best] - s;
          t = frag_acc + r.ifrag;
          frag_acc = (t > SUM_MAX) ? SUM_MAX : t[TOTAL_W-1:0];
        end else if (fail_cnt < LOG_DEPTH) begin
          fail_log[fail_cnt] = s;
          fail_cnt++;
          r.status = STATUS_NOFIT;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      default: begin
        for (int j = 0; j < part_cnt; j++) begin
          if (!part_taken[j]) free_sum += part_size[j];
        end
        r.ftotal = (free_sum > FREE_MAX) ? FREE_MAX : free_t'(free_sum);
        // compare against the unsaturated sum
        for (int j = 0; j < fail_cnt; j++) begin
          if (fail_log[j] < free_sum && fail_log[j] > r.efrag) r.efrag = fail_log[j];
        end
      end
    endcase
    r.itotal = frag_acc;
    return r;
  endfunction

  // Mostly small sizes and sizes near loaded partitions, some extremes.
  function automatic size_t pick_size();
    int k;
    int idx;
    k = $urandom_range(0, 9);
    case (k) inside
      0: return '0;
      1: return '1;
      2, 3, 4: return size_t'($urandom_range(0, 300));
      5, 6: return size_t'($urandom);
      default: begin
        if (part_cnt == 0) return size_t'($urandom_range(0, 300));
        idx = $urandom_range(0, part_cnt - 1);
        return size_t'(part_size[idx] + $urandom_range(0, 2) - 1);
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH response %0d %s: got %0d expected %0d", rsp_seen, what, got, want);
    errors++;
  endtask

  task automatic check_rsp(input alloc_rsp_t want);
    if (rsp_if.status !== want.status) flag_mismatch("status", rsp_if.status, want.status);
    if (rsp_if.granted !== want.granted)
      flag_mismatch("granted", rsp_if.granted, want.granted);
    if (rsp_if.partition_index !== want.index)
      flag_mismatch("partition_index", rsp_if.partition_index, want.index);
    if (rsp_if.internal_frag !== want.ifrag)
      flag_mismatch("internal_frag", rsp_if.internal_frag, want.ifrag);
    if (rsp_if.internal_total !== want.itotal)
      flag_mismatch("internal_total", rsp_if.internal_total, want.itotal);
    if (rsp_if.free_total !== want.ftotal)
      flag_mismatch("free_total", rsp_if.free_total, want.ftotal);
    if (rsp_if.external_frag !== want.efrag)
      flag_mismatch("external_frag", rsp_if.external_frag, want.efrag);
  endtask

  task automatic send_req(input mode_t m, input size_t s, input logic typed = 1'b0,
                          input alloc_rsp_t want = '0);
    alloc_rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= m;
    req_if.size_value <= s;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = best_fit_step(m, s);
    expected_rsps.push_back(typed ? want : predicted);
    accepted_reqs++;
  endtask

  // One episode: usually clear, load some partitions, then mixed traffic.
  task automatic run_episode();
    int loads;
    int ops;
    int pick;
    if ($urandom_range(0, 9) != 0) send_req(MODE_CLEAR, size_t'($urandom));
    loads = $urandom_range(0, 17);
    repeat (loads) send_req(MODE_LOAD, pick_size());
    ops = $urandom_range(4, 48);
    repeat (ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) send_req(MODE_ALLOC, pick_size());
      else if (pick < 80) send_req(MODE_REPORT, size_t'($urandom));
      else if (pick < 90) send_req(MODE_LOAD, pick_size());
      else if (pick < 92) send_req(MODE_CLEAR, size_t'($urandom));
      else send_req(mode_t'($urandom_range(0, 3)), size_t'($urandom));
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
        rsp_if.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_given   <= hold_given + 1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        flag_mismatch("response with none pending", 1, 0);
      end else begin
        check_rsp(expected_rsps.pop_front());
      end
      rsp_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_CLEAR;
    req_if.size_value = '0;
    part_cnt          = 0;
    fail_cnt          = 0;
    frag_acc          = '0;
    for (int j = 0; j < PARTS; j++) part_taken[j] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      repeat (dir_rows[r].reps) begin
        send_req(dir_rows[r].mode, dir_rows[r].req_size, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 52; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 52; end
        default: begin send_idle_pct = 19; stall_pct <= 19; end
      endcase
      // hold off the receiver while requests keep coming
      if (ph == 0) hold_asked <= hold_asked + 1;
      while (accepted_reqs < DIR_ROWS + (ph + 1) * (RAND_ITEMS / 4)) run_episode();
    end
    req_if.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
